>>> hdl/gcb_pkg.sv
// shared types and constants for the graph connectivity walker
package gcb_pkg;

  localparam int VFIELD_W = 6;
  localparam int VERT_SPAN = 1 << VFIELD_W;
  localparam int COUNT_W = 7;
  localparam logic [COUNT_W-1:0] VCOUNT_RESET = 7'd64;

  typedef enum logic [2:0] {
    S_LOAD,
    S_START,
    S_ROW,
    S_SCAN,
    S_QRD,
    S_DONE
  } gcb_state_t;

  typedef struct packed {
    logic wr;
    logic rd;
    logic clr;
  } adj_ctl_t;

endpackage

>>> hdl/gcb_adj_store.sv
// adjacency bit matrix: one synchronous memory row per vertex, per-row valid bits
module gcb_adj_store
  import gcb_pkg::*;
#(
  parameter int NV   = 64,
  parameter int VI_W = 6
) (
  input  logic            clk,
  input  logic            rst_n,
  input  adj_ctl_t        ctl,
  input  logic [VI_W-1:0] wr_row,
  input  logic [VI_W-1:0] wr_col,
  input  logic [VI_W-1:0] rd_row,
  output logic [NV-1:0]   rd_data
);

  logic [NV-1:0] adj_mem [NV];
  logic [NV-1:0] row_valid_r;
  logic [NV-1:0] row_q_r;
  logic          row_ok_r;
  logic [NV-1:0] col_onehot;

  assign col_onehot = NV'(1) << wr_col;

  // first write to a stale row replaces it whole, later writes set one bit
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      if (row_valid_r[wr_row]) begin
        adj_mem[wr_row][wr_col] <= 1'b1;
      end else begin
        adj_mem[wr_row] <= col_onehot;
      end
    end
    if (ctl.rd) begin
      row_q_r <= adj_mem[rd_row];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      row_ok_r    <= 1'b0;
    end else begin
      if (ctl.clr) begin
        row_valid_r <= '0;
      end else if (ctl.wr) begin
        row_valid_r[wr_row] <= 1'b1;
      end
      if (ctl.rd) begin
        row_ok_r <= row_valid_r[rd_row];
      end
    end
  end

  assign rd_data = row_ok_r ? row_q_r : '0;

endmodule

>>> hdl/graph_connectivity_bfs.sv
// top level: edge loader, breadth-first walk over the adjacency store, result register
// walk: after the last edge, each reached vertex's row is read once from the adjacency
// store and each newly discovered vertex is written to the queue before the result is registered
// throughput: one edge per cycle while loading, no input taken during the walk
// reset: synchronous active-low; vertex_count returns to 64, matrix rows read as empty
module graph_connectivity_bfs
  import gcb_pkg::*;
#(
  parameter int MAX_VERTICES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [5:0] from_vertex, [11:6] to_vertex, [15:12] zero
  input  logic        in_tlast,   // last_edge
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [6:0] reached_count, [7] connected
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data    // vertex_count
);

  localparam int NV   = (MAX_VERTICES < VERT_SPAN) ? MAX_VERTICES : VERT_SPAN;
  localparam int VI_W = (NV > 1) ? $clog2(NV) : 1;

  gcb_state_t           state_r, state_nxt;
  logic [COUNT_W-1:0]   vcount_r;
  logic [NV-1:0]        visited_r, visited_nxt;
  logic [NV-1:0]        pending_r, pending_nxt;
  logic [VI_W-1:0]      head_r, head_nxt;
  logic [VI_W-1:0]      tail_r, tail_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [COUNT_W-1:0]   out_count_r, out_count_nxt;
  logic                 out_conn_r, out_conn_nxt;

  logic [VI_W-1:0]      q_mem [NV];
  logic                 q_we, q_re;
  logic [VI_W-1:0]      q_rd_r;

  adj_ctl_t             adj_ctl;
  logic [VI_W-1:0]      adj_rd_row;
  logic [NV-1:0]        adj_rd_data;
  logic [NV-1:0]        vmask;
  logic [NV-1:0]        pick_onehot;
  logic [VI_W-1:0]      pick;
  logic [VFIELD_W-1:0]  from_f, to_f;
  logic                 edge_ok, in_xfer;

  function automatic logic [VI_W-1:0] lowest_set(input logic [NV-1:0] vec);
    logic [VI_W-1:0] idx;
    idx = '0;
    for (int i = NV - 1; i >= 0; i--) begin
      if (vec[i]) idx = VI_W'(i);
    end
    return idx;
  endfunction

  assign from_f  = in_tdata[VFIELD_W-1:0];
  assign to_f    = in_tdata[2*VFIELD_W-1:VFIELD_W];
  assign edge_ok = (int'(from_f) < MAX_VERTICES) && (int'(to_f) < MAX_VERTICES);
  assign in_xfer = in_tvalid && in_tready;

  assign in_tready  = (state_r == S_LOAD);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_conn_r, out_count_r};

  // walk never follows edges into vertices at or above vertex_count
  for (genvar g = 0; g < NV; g++) begin : g_vmask
    assign vmask[g] = (COUNT_W'(g) < vcount_r);
  end

  assign pick        = lowest_set(pending_r);
  assign pick_onehot = NV'(1) << pick;

  gcb_adj_store #(
    .NV   (NV),
    .VI_W (VI_W)
  ) u_adj (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (adj_ctl),
    .wr_row  (from_f[VI_W-1:0]),
    .wr_col  (to_f[VI_W-1:0]),
    .rd_row  (adj_rd_row),
    .rd_data (adj_rd_data)
  );

  // discovery queue
  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[tail_r] <= pick;
    end
    if (q_re) begin
      q_rd_r <= q_mem[head_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      vcount_r    <= VCOUNT_RESET;
      visited_r   <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      visited_r   <= visited_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        vcount_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pending_r   <= pending_nxt;
    out_count_r <= out_count_nxt;
    out_conn_r  <= out_conn_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    visited_nxt   = visited_r;
    pending_nxt   = pending_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_count_nxt = out_count_r;
    out_conn_nxt  = out_conn_r;
    adj_ctl       = '0;
    adj_rd_row    = '0;
    q_we          = 1'b0;
    q_re          = 1'b0;

    unique case (state_r)
      S_LOAD: begin
        if (in_xfer) begin
          adj_ctl.wr = edge_ok;
          if (in_tlast) begin
            state_nxt = S_START;
          end
        end
      end
      S_START: begin
        // vertex 0 is reached by definition; its row is fetched directly
        visited_nxt = NV'(1);
        head_nxt    = '0;
        tail_nxt    = '0;
        count_nxt   = COUNT_W'(1);
        adj_ctl.rd  = 1'b1;
        adj_rd_row  = '0;
        state_nxt   = S_ROW;
      end
      S_ROW: begin
        pending_nxt = adj_rd_data & ~visited_r & vmask;
        state_nxt   = S_SCAN;
      end
      S_SCAN: begin
        priority if (pending_r != '0) begin
          q_we        = 1'b1;
          visited_nxt = visited_r | pick_onehot;
          pending_nxt = pending_r & ~pick_onehot;
          tail_nxt    = tail_r + VI_W'(1);
          count_nxt   = count_r + COUNT_W'(1);
        end else if (head_r != tail_r) begin
          q_re      = 1'b1;
          head_nxt  = head_r + VI_W'(1);
          state_nxt = S_QRD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_QRD: begin
        adj_ctl.rd = 1'b1;
        adj_rd_row = q_rd_r;
        state_nxt  = S_ROW;
      end
      S_DONE: begin
        // hold until the result register is free, then clear the graph
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = count_r;
          out_conn_nxt  = (count_r == vcount_r);
          adj_ctl.clr   = 1'b1;
          visited_nxt   = '0;
          state_nxt     = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

endmodule
